@@ rtl/ihs_pkg.sv @@
// Package for the index header sorter: widths, status codes and item types.
// Used by every module of the block but ihs_ram; no dependencies.
`default_nettype none
package ihs_pkg;
  localparam int Entries = 1024;
  localparam int AddrW = $clog2(Entries);
  localparam int CntW = AddrW + 1;
  localparam int OffW = 48;
  localparam logic [31:0] MagicReset = 32'h11ef55aa;
  localparam logic [OffW-1:0] OffsetMax = {OffW{1'b1}};

  typedef enum logic [2:0] {
    ST_STORED = 3'd0, ST_SKIPPED = 3'd1, ST_BAD_MAGIC = 3'd2, ST_RANGE = 3'd3,
    ST_FULL = 3'd4, ST_ENTRY = 3'd5, ST_EMPTY = 3'd6
  } status_t;

  typedef struct packed {
    logic        action;
    logic [31:0] magic;
    logic [31:0] user_key;
    logic [31:0] hash_count;
    logic [31:0] list_count;
  } in_item_t;

  typedef struct packed {
    logic [25:0] key;
    logic [23:0] hc;
    logic [25:0] lc;
    logic [OffW-1:0] off;
  } entry_t;

  // Classified work handed from the front to the back.
  typedef enum logic [1:0] {
    OP_STATUS = 2'd0, OP_INSERT = 2'd1, OP_READ = 2'd2
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t status;
    entry_t  entry;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [25:0] entry_key;
    logic [23:0] entry_hash_count;
    logic [25:0] entry_list_count;
    logic [OffW-1:0] entry_offset;
    logic        last;
  } out_item_t;

  localparam int EntW = $bits(entry_t);
  localparam int CmdW = $bits(cmd_t);
endpackage
`default_nettype wire

@@ rtl/ihs_if.sv @@
// Valid/ready channel interfaces for the index header sorter.
// Depends on ihs_pkg for the input and result item types.
`default_nettype none
interface ihs_in_if (input wire logic clk);
  logic valid;
  logic ready;
  ihs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ihs_out_if (input wire logic clk);
  logic valid;
  logic ready;
  ihs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/index_header_sorter.sv @@
// Top level of the index header sorter: front end, queue and back end.
// Depends on ihs_pkg, ihs_if, ihs_front, ihs_queue and ihs_back.
//
//   Channel   Direction  Handshake          Carries
//   in_       sink       valid / ready      header or read request
//   out_      source     valid / ready      one status result per item
//   cfg_      write      wr_en / wr_data    expected magic word
//
// An item is always registered in the queue before the back end takes it. In
// the back end a status-only item or a read with nothing left is answered from
// S_IDLE, a read that returns an entry passes S_RDW and S_RDOUT, and a stored
// header takes an S_SCAN and an S_CMP step for each table entry with a larger
// key, which it reads and moves up, until a smaller or equal key or the bottom
// of the table ends the walk. Reset is synchronous and needs no clearing pass.
// Either side may stall; the queue and the result register decouple them.
`default_nettype none
module index_header_sorter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  ihs_in_if.sink     in_ch,
  ihs_out_if.source  out_ch
);
  import ihs_pkg::*;

  logic [31:0] magic_r;
  logic        f_valid, f_ready, b_valid, b_ready;
  cmd_t        f_cmd, b_cmd;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MagicReset;
    end else if (cfg_wr_en) begin
      magic_r <= cfg_wr_data;
    end
  end

  ihs_front u_front (
    .clk(clk), .rst_n(rst_n), .magic_word(magic_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_cmd)
  );

  ihs_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .w_valid(f_valid), .w_ready(f_ready), .w_data(f_cmd),
    .r_valid(b_valid), .r_ready(b_ready), .r_data(b_cmd)
  );

  ihs_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_data(b_cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

  // A result that is stalled must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("stalled result changed");

  // The last flag only comes with an entry.
  a_last_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.last |-> out_ch.data.status == ST_ENTRY)
    else $error("last flag without entry");

  // An input transfer only happens when the queue has room.
  a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> f_ready)
    else $error("transfer into a full queue");
endmodule
`default_nettype wire

@@ rtl/ihs_ram.sv @@
// Generic single-port-write, one-read RAM with a registered read.
// No dependencies.
`default_nettype none
module ihs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port; a read of the address being written
  // returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/ihs_front.sv @@
// Front end: checks headers, keeps the running offset, issues commands.
// Depends on ihs_pkg.
`default_nettype none
module ihs_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [31:0]    magic_word,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ihs_pkg::in_item_t in_data,
  output logic                cmd_valid,
  input  wire logic           cmd_ready,
  output ihs_pkg::cmd_t       cmd_data
);
  import ihs_pkg::*;

  logic [OffW-1:0] run_off_r, run_off_nxt;
  logic [OffW:0]   after_sum, body_sum;
  logic [OffW-1:0] after_hdr;
  logic [31:0]     body;
  logic            range_bad, key_skip, hdr_ok;
  cmd_t            cmd;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign cmd_data  = cmd;

  // Header checks and the saturating offset arithmetic.
  always_comb begin
    range_bad = (in_data.user_key[31]) || (in_data.hash_count[31:24] != '0)
             || (in_data.list_count[31:26] != '0);
    key_skip  = (in_data.user_key == '0) || (in_data.user_key[30:26] != '0);
    after_sum = {1'b0, run_off_r} + (OffW+1)'(32);
    after_hdr = after_sum[OffW] ? OffsetMax : after_sum[OffW-1:0];
    body      = {4'd0, in_data.hash_count[23:0], 4'd0}
              + {4'd0, in_data.list_count[25:0], 2'd0};
    body_sum  = {1'b0, after_hdr} + (OffW+1)'(body);
    hdr_ok    = 1'b0;
    cmd       = '0;
    cmd.entry.key = in_data.user_key[25:0];
    cmd.entry.hc  = in_data.hash_count[23:0];
    cmd.entry.lc  = in_data.list_count[25:0];
    cmd.entry.off = after_hdr;
    if (in_data.action) begin
      cmd.op = OP_READ;
    end else if (in_data.magic != magic_word) begin
      cmd.op = OP_STATUS;
      cmd.status = ST_BAD_MAGIC;
    end else if (range_bad) begin
      cmd.op = OP_STATUS;
      cmd.status = ST_RANGE;
    end else begin
      hdr_ok = 1'b1;
      if (key_skip) begin
        cmd.op = OP_STATUS;
        cmd.status = ST_SKIPPED;
      end else begin
        cmd.op = OP_INSERT;
      end
    end
    run_off_nxt = run_off_r;
    if (hdr_ok) begin
      run_off_nxt = body_sum[OffW] ? OffsetMax : body_sum[OffW-1:0];
    end
  end

  // The offset moves when a good header transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_off_r <= '0;
    end else if (in_valid && in_ready) begin
      run_off_r <= run_off_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/ihs_queue.sv @@
// Two-entry command queue between the front and back ends.
// Depends on ihs_pkg.
`default_nettype none
module ihs_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           w_valid,
  output logic                w_ready,
  input  wire ihs_pkg::cmd_t  w_data,
  output logic                r_valid,
  input  wire logic           r_ready,
  output ihs_pkg::cmd_t       r_data
);
  import ihs_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign w_ready = (cnt_r != 2'd2);
  assign r_valid = (cnt_r != 2'd0);
  assign r_data  = slot_r[rp_r];
  assign push    = w_valid && w_ready;
  assign pop     = r_valid && r_ready;

  // Payload slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= w_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ rtl/ihs_back.sv @@
// Back end: sorted table in RAM, insertion by shifting, reads, result register.
// Depends on ihs_pkg and ihs_ram.
`default_nettype none
module ihs_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire ihs_pkg::cmd_t  cmd_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ihs_pkg::out_item_t  out_data
);
  import ihs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CMP   = 5'b00100,
    S_RDW   = 5'b01000,
    S_RDOUT = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] rptr_r, rptr_nxt;
  logic [CntW-1:0] pos_r, pos_nxt;
  entry_t          new_r, new_nxt;
  out_item_t       res_r, res_nxt;
  logic            res_v_r, res_v_nxt;
  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  entry_t          wdata, rdata;
  logic [EntW-1:0] rdata_raw;
  logic            free;

  assign rdata     = entry_t'(rdata_raw);
  assign out_valid = res_v_r;
  assign out_data  = res_r;
  assign free      = !res_v_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE) && free;

  ihs_ram #(.Width(EntW), .Depth(Entries)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(EntW'(wdata)),
    .raddr(raddr), .rdata(rdata_raw)
  );

  // Insertion walks down from the top, reading pos-1 and moving it up.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rptr_nxt  = rptr_r;
    pos_nxt   = pos_r;
    new_nxt   = new_r;
    res_nxt   = res_r;
    res_v_nxt = res_v_r && !out_ready;
    we        = 1'b0;
    waddr     = pos_r[AddrW-1:0];
    wdata     = new_r;
    raddr     = AddrW'(pos_r - CntW'(1));
    case (state_r)
      S_IDLE: begin
        raddr = rptr_r[AddrW-1:0];
        if (cmd_valid && free) begin
          res_nxt = '0;
          case (cmd_data.op)
            OP_STATUS: begin
              res_nxt.status = cmd_data.status;
              res_v_nxt = 1'b1;
            end
            OP_INSERT: begin
              if (count_r >= CntW'(Entries)) begin
                res_nxt.status = ST_FULL;
                res_v_nxt = 1'b1;
              end else begin
                new_nxt = cmd_data.entry;
                pos_nxt = count_r;
                state_nxt = S_SCAN;
              end
            end
            OP_READ: begin
              if (count_r == '0 || rptr_r >= count_r) begin
                res_nxt.status = ST_EMPTY;
                res_v_nxt = 1'b1;
              end else begin
                state_nxt = S_RDW;
              end
            end
            default: begin
              res_nxt.status = ST_EMPTY;
              res_v_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Read of pos-1 issued; empty-below position ends the walk.
        if (pos_r == '0) begin
          we = 1'b1;
          count_nxt = count_r + CntW'(1);
          res_nxt.status = ST_STORED;
          res_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rdata.key > new_r.key) begin
          we = 1'b1;
          wdata = rdata;
          pos_nxt = pos_r - CntW'(1);
          state_nxt = S_SCAN;
        end else begin
          we = 1'b1;
          count_nxt = count_r + CntW'(1);
          res_nxt.status = ST_STORED;
          res_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RDW: begin
        raddr = rptr_r[AddrW-1:0];
        state_nxt = S_RDOUT;
      end
      S_RDOUT: begin
        res_nxt.status = ST_ENTRY;
        res_nxt.entry_key = rdata.key;
        res_nxt.entry_hash_count = rdata.hc;
        res_nxt.entry_list_count = rdata.lc;
        res_nxt.entry_offset = rdata.off;
        res_v_nxt = 1'b1;
        if (rptr_r + CntW'(1) >= count_r) begin
          res_nxt.last = 1'b1;
          count_nxt = '0;
          rptr_nxt = '0;
        end else begin
          rptr_nxt = rptr_r + CntW'(1);
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result payload and working entry.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    new_r <= new_nxt;
    pos_r <= pos_nxt;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rptr_r  <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rptr_r  <= rptr_nxt;
      res_v_r <= res_v_nxt;
    end
  end
endmodule
`default_nettype wire
